### rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int WORD_W      = BYTE_W * MAX_PATTERN;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_BYTES = 2'd0,
        CFG_PAT_LEN   = 2'd1,
        CFG_REP_BYTES = 2'd2,
        CFG_REP_LEN   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              bare;
    } t_job;

endpackage

### rtl/sfr_cell.sv
module sfr_cell
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_prev,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic              i_keep,
    input  logic              i_load,
    input  logic              i_clr,
    output logic              o_flag,
    output logic              o_hit
);

    logic r_flag;

    assign o_hit  = i_prev && (i_byte == i_pat);
    assign o_flag = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_flag <= 1'b0;
        end else if (i_load) begin
            r_flag <= o_hit && i_keep;
        end
    end

endmodule

### rtl/sfr_emit.sv
module sfr_emit
    import sfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_job              i_job,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_out_last
);

    t_job             r_pend;
    logic             r_pfull;
    logic [WORD_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;
    logic             r_bare;

    logic fire;
    logic out_free;
    logic move;
    logic direct;

    assign fire     = (r_cnt != '0) && !i_stall;
    assign out_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && !i_stall);
    assign move     = r_pfull && out_free;
    assign direct   = i_load && !r_pfull && out_free;

    assign o_full       = r_pfull;
    assign o_valid      = (r_cnt != '0);
    assign o_out_byte   = r_bytes[BYTE_W-1:0];
    assign o_byte_valid = !r_bare;
    assign o_out_last   = r_last && (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfull <= 1'b0;
        end else if (move) begin
            r_pfull <= 1'b0;
        end else if (i_load && !direct) begin
            r_pfull <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !direct) begin
            r_pend <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (move) begin
            r_cnt <= r_pend.count;
        end else if (direct) begin
            r_cnt <= i_job.count;
        end else if (fire) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_bytes <= r_pend.bytes;
            r_last  <= r_pend.last;
            r_bare  <= r_pend.bare;
        end else if (direct) begin
            r_bytes <= i_job.bytes;
            r_last  <= i_job.last;
            r_bare  <= i_job.bare;
        end else if (fire) begin
            r_bytes <= r_bytes >> BYTE_W;
        end
    end

endmodule

### rtl/stream_find_replace_top.sv
// Latency: a request's first result appears in the cycle after it is accepted when the output
// register is free; otherwise the request waits in a one-deep pending slot until it drains.
// Throughput: one input byte per cycle while each request yields at most one result and the output
// is not stalled; a request that yields k results keeps the output register busy until all k have
// been taken, and the input stalls while the pending slot is full.
// Synchronous active-low reset empties the window and queue and restores the configuration.
module stream_find_replace_top
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_in_last,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_out_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    logic [WORD_W-1:0] r_pat_bytes;
    logic [CNT_W-1:0]  r_pat_len;
    logic [WORD_W-1:0] r_rep_bytes;
    logic [CNT_W-1:0]  r_rep_len;

    logic [CNT_W-1:0]       p_eff;
    logic [CNT_W-1:0]       rep_eff;
    logic [2:0]             p_top;
    logic                   accept;
    logic                   pat_write;
    logic                   match;
    logic                   clr;
    logic [MAX_PATTERN-1:0] flag;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] keep;
    logic [CNT_W-1:0]       held;
    logic [CNT_W-1:0]       new_held;
    logic [WORD_W-1:0]      window;
    t_job                   job;
    logic                   full;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = full;
    assign pat_write = i_cfg_we && ((t_cfg_reg'(i_cfg_index) == CFG_PAT_BYTES) ||
                                    (t_cfg_reg'(i_cfg_index) == CFG_PAT_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= CNT_W'(1);
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PAT_BYTES: r_pat_bytes <= i_cfg_data;
                CFG_PAT_LEN:   r_pat_len   <= i_cfg_data[CNT_W-1:0];
                CFG_REP_BYTES: r_rep_bytes <= i_cfg_data;
                CFG_REP_LEN:   r_rep_len   <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (r_pat_len == '0) begin
            p_eff = CNT_W'(1);
        end else if (r_pat_len > CNT_W'(MAX_PATTERN)) begin
            p_eff = CNT_W'(MAX_PATTERN);
        end else begin
            p_eff = r_pat_len;
        end
        if (r_rep_len > CNT_W'(MAX_REPLACE)) begin
            rep_eff = CNT_W'(MAX_REPLACE);
        end else begin
            rep_eff = r_rep_len;
        end
    end

    assign p_top = 3'(p_eff - CNT_W'(1));
    assign match = hit[p_top];
    assign clr   = pat_write || (accept && (match || i_in_last));

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic prev;
        if (j == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = flag[j-1];
        end
        assign keep[j] = (CNT_W'(j + 1) < p_eff);
        sfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_prev  (prev),
            .i_byte  (i_in_byte),
            .i_pat   (r_pat_bytes[BYTE_W*j +: BYTE_W]),
            .i_keep  (keep[j]),
            .i_load  (accept),
            .i_clr   (clr),
            .o_flag  (flag[j]),
            .o_hit   (hit[j])
        );
    end

    always_comb begin
        held     = '0;
        new_held = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (flag[j]) begin
                held = CNT_W'(j + 1);
            end
            if (hit[j] && keep[j]) begin
                new_held = CNT_W'(j + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < held) begin
                window[BYTE_W*i +: BYTE_W] = r_pat_bytes[BYTE_W*i +: BYTE_W];
            end else if (CNT_W'(i) == held) begin
                window[BYTE_W*i +: BYTE_W] = i_in_byte;
            end else begin
                window[BYTE_W*i +: BYTE_W] = '0;
            end
        end
    end

    always_comb begin
        job.last = i_in_last;
        job.bare = 1'b0;
        priority if (match && i_in_last && (rep_eff == '0)) begin
            job.bytes = '0;
            job.count = CNT_W'(1);
            job.bare  = 1'b1;
        end else if (match) begin
            job.bytes = r_rep_bytes;
            job.count = rep_eff;
        end else if (i_in_last) begin
            job.bytes = window;
            job.count = held + CNT_W'(1);
        end else begin
            job.bytes = window;
            job.count = held + CNT_W'(1) - new_held;
        end
    end

    sfr_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && (job.count != '0)),
        .i_job        (job),
        .o_full       (full),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last)
    );

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 120;
    localparam int STALL_LIMIT     = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_ok;
        logic              last;
    } t_text_item;

    typedef struct packed {
        logic              is_cfg;
        t_cfg_reg          reg_idx;
        logic [WORD_W-1:0] value;
        logic              last;
        logic              typed;
        logic [1:0]        n_typed;
        t_text_item        res0;
        t_text_item        res1;
    } t_stim_row;

    localparam t_text_item NO_ITEM = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_in_byte;
    logic                 i_in_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_byte_valid;
    logic                 o_out_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    stream_find_replace_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [WORD_W-1:0] pat_word;
    logic [WORD_W-1:0] rep_word;
    logic [3:0]        pat_len_reg;
    logic [3:0]        rep_len_reg;
    logic [7:0]        held_q [0:6];
    int                held_n;

    t_text_item step_out[$];
    t_text_item expected_text[$];
    t_text_item want;
    t_stim_row  dir_table[$];

    bit hold_request = 1'b0;
    bit steady_flow  = 1'b0;

    int n_requests = 0;
    int n_streams  = 0;
    int n_hits     = 0;
    int n_results  = 0;
    int n_writes   = 0;
    int n_errors   = 0;

    function automatic t_stim_row row_cfg(input t_cfg_reg idx, input logic [WORD_W-1:0] value);
        t_stim_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic t_stim_row row_item(input logic [7:0] b, input logic last);
        t_stim_row r;
        r = '0;
        r.value[7:0] = b;
        r.last       = last;
        return r;
    endfunction

    function automatic t_stim_row row_seen(input logic [7:0] b, input logic last,
                                           input logic [1:0] n,
                                           input t_text_item r0, input t_text_item r1);
        t_stim_row r;
        r = row_item(b, last);
        r.typed   = 1'b1;
        r.n_typed = n;
        r.res0    = r0;
        r.res1    = r1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch at result %0d: %s is %0h, expected %0h",
                     n_results, what, got, exp_val);
    endtask

    // Applies one request to the window and collects the results it produces.
    task automatic rewrite_step(input logic [7:0] b, input logic last);
        logic [7:0] win [0:7];
        int         p;
        int         r;
        int         n;
        int         start;
        int         len;
        bit         prefix;
        t_text_item item;
        p = (pat_len_reg == 0) ? 1 : ((pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg);
        r = (rep_len_reg > MAX_REPLACE) ? MAX_REPLACE : rep_len_reg;
        step_out.delete();
        for (int i = 0; i < held_n; i++) win[i] = held_q[i];
        win[held_n] = b;
        n = held_n + 1;
        start = 0;
        forever begin
            len = n - start;
            prefix = (len <= p);
            for (int i = 0; prefix && i < len; i++)
                if (win[start + i] != pat_word[8*i +: 8]) prefix = 1'b0;
            if (prefix) break;
            item = '{data: win[start], data_ok: 1'b1, last: 1'b0};
            step_out.push_back(item);
            start++;
        end
        len = n - start;
        if (len == p) begin
            for (int i = 0; i < r; i++) begin
                item = '{data: rep_word[8*i +: 8], data_ok: 1'b1, last: 1'b0};
                step_out.push_back(item);
            end
            held_n = 0;
            n_hits++;
        end else begin
            for (int i = 0; i < len; i++) held_q[i] = win[start + i];
            held_n = len;
        end
        if (last) begin
            for (int i = 0; i < held_n; i++) begin
                item = '{data: held_q[i], data_ok: 1'b1, last: 1'b0};
                step_out.push_back(item);
            end
            held_n = 0;
            if (step_out.size() == 0) step_out.push_back(NO_ITEM);
            step_out[step_out.size() - 1].last = 1'b1;
        end
    endtask

    // Lowers valid and waits until every expected result has come and the block is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [WORD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        unique case (idx)
            CFG_PAT_BYTES: begin
                pat_word = value;
                held_n   = 0;
            end
            CFG_PAT_LEN: begin
                pat_len_reg = value[3:0];
                held_n      = 0;
            end
            CFG_REP_BYTES: rep_word = value;
            CFG_REP_LEN:   rep_len_reg = value[3:0];
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_request(input t_stim_row row);
        while (!steady_flow && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= row.value[7:0];
        i_in_last <= row.last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        rewrite_step(row.value[7:0], row.last);
        if (row.typed) begin
            if (row.n_typed > 0) expected_text.push_back(row.res0);
            if (row.n_typed > 1) expected_text.push_back(row.res1);
        end else begin
            foreach (step_out[j]) expected_text.push_back(step_out[j]);
        end
        n_requests++;
        if (row.last) n_streams++;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int ph);
        logic [WORD_W-1:0] pat;
        logic [WORD_W-1:0] rep;
        logic [WORD_W-1:0] noise;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic [7:0]        phase_text[$];
        int                plen_w;
        int                rlen_w;
        int                p;
        int                choice;
        int                cut;
        pat   = {$urandom, $urandom};
        rep   = {$urandom, $urandom};
        noise = {$urandom, $urandom};
        if ($urandom_range(1) == 1) begin
            a0 = 8'($urandom);
            a1 = 8'($urandom);
            for (int k = 0; k < 8; k++) pat[8*k +: 8] = ($urandom_range(1) == 1) ? a1 : a0;
        end
        plen_w = ($urandom_range(3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        if ($urandom_range(9) == 0) plen_w = ($urandom_range(1) == 1) ? 0 : $urandom_range(9, 15);
        rlen_w = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        if (ph == 0) begin
            pat    = '0;
            rep    = '0;
            plen_w = 8;
            rlen_w = 8;
        end
        settle();
        write_reg(CFG_PAT_BYTES, pat);
        write_reg(CFG_PAT_LEN, {noise[63:4], 4'(plen_w)});
        write_reg(CFG_REP_BYTES, rep);
        noise = {$urandom, $urandom};
        write_reg(CFG_REP_LEN, {noise[63:4], 4'(rlen_w)});
        p = (plen_w == 0) ? 1 : ((plen_w > MAX_PATTERN) ? MAX_PATTERN : plen_w);

        // Mostly whole and broken occurrences of the pattern, with some noise.
        while (phase_text.size() < ITEMS_PER_PHASE) begin
            choice = $urandom_range(99);
            if (choice < 45) begin
                for (int k = 0; k < p; k++) phase_text.push_back(pat[8*k +: 8]);
            end else if (choice < 65 && p > 1) begin
                cut = $urandom_range(1, p - 1);
                for (int k = 0; k < cut; k++) phase_text.push_back(pat[8*k +: 8]);
            end else if (choice < 85) begin
                cut = $urandom_range(0, p - 1);
                phase_text.push_back(pat[8*cut +: 8]);
            end else begin
                phase_text.push_back(8'($urandom));
            end
        end

        if (ph == 3) hold_request = 1'b1;
        if (ph == 6) steady_flow = 1'b1;
        foreach (phase_text[k]) begin
            if (ph == 8 && k == ITEMS_PER_PHASE / 2) settle();
            send_request(row_item(phase_text[k],
                                  k == phase_text.size() - 1 || $urandom_range(99) < 4));
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            n_results++;
            if (expected_text.size() == 0) begin
                report_mismatch("result with nothing pending, out_byte", int'(o_out_byte), 0);
            end else begin
                want = expected_text.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", int'(o_out_byte), int'(want.data));
                if (o_byte_valid !== want.data_ok)
                    report_mismatch("byte_valid", int'(o_byte_valid), int'(want.data_ok));
                if (o_out_last !== want.last)
                    report_mismatch("out_last", int'(o_out_last), int'(want.last));
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_stall <= !steady_flow && ($urandom_range(99) < 36);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) quiet = 0;
            else quiet++;
        end
        $display("[stream_find_replace_top] ERROR");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in_byte   = '0;
        i_in_last   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_PAT_BYTES;
        i_cfg_data  = '0;
        pat_word    = '0;
        rep_word    = '0;
        pat_len_reg = 4'd1;
        rep_len_reg = 4'd0;
        held_n      = 0;

        dir_table = '{
            // After reset the pattern is the single byte zero and matches are deleted.
            row_seen(8'h41, 1'b0, 2'd1, '{8'h41, 1'b1, 1'b0}, NO_ITEM),
            row_seen(8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM),
            row_seen(8'hFF, 1'b0, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_ITEM),
            row_seen(8'h00, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_ITEM),
            row_seen(8'h80, 1'b1, 2'd1, '{8'h80, 1'b1, 1'b1}, NO_ITEM),
            row_cfg(CFG_PAT_BYTES, 64'h636261),
            row_cfg(CFG_PAT_LEN, 64'd3),
            row_cfg(CFG_REP_BYTES, 64'h5958),
            row_cfg(CFG_REP_LEN, 64'd2),
            row_item(8'h61, 1'b0),
            row_item(8'h62, 1'b0),
            row_item(8'h63, 1'b0),
            row_item(8'h61, 1'b0),
            row_item(8'h61, 1'b0),
            row_item(8'h62, 1'b0),
            row_item(8'h78, 1'b0),
            row_item(8'h61, 1'b0),
            row_item(8'h62, 1'b0),
            // Rewriting the pattern length drops the two held bytes.
            row_cfg(CFG_PAT_LEN, 64'd3),
            row_item(8'h63, 1'b1),
            // Zero pattern length acts as one and an oversized replacement saturates.
            row_cfg(CFG_PAT_BYTES, '1),
            row_cfg(CFG_PAT_LEN, 64'd0),
            row_cfg(CFG_REP_BYTES, '1),
            row_cfg(CFG_REP_LEN, 64'd15),
            row_item(8'hFF, 1'b0),
            row_item(8'hFF, 1'b1),
            // An oversized pattern length saturates, and a deleted final match ends bare.
            row_cfg(CFG_PAT_BYTES, 64'h0807060504030201),
            row_cfg(CFG_PAT_LEN, 64'd15),
            row_cfg(CFG_REP_LEN, 64'd0),
            row_item(8'h01, 1'b0),
            row_item(8'h02, 1'b0),
            row_item(8'h03, 1'b0),
            row_item(8'h04, 1'b0),
            row_item(8'h05, 1'b0),
            row_item(8'h06, 1'b0),
            row_item(8'h07, 1'b0),
            row_item(8'h08, 1'b1),
            row_item(8'h01, 1'b1)
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                settle();
                write_reg(dir_table[i].reg_idx, dir_table[i].value);
            end else begin
                send_request(dir_table[i]);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) random_phase(ph);

        settle();
        $display("Run covered %0d requests in %0d streams with %0d pattern hits;",
                 n_requests, n_streams, n_hits);
        $display("%0d results checked after %0d register writes, with odd lengths included.",
                 n_results, n_writes);
        if (n_errors == 0) begin
            $display("[stream_find_replace_top] OK");
        end else begin
            $display("[stream_find_replace_top] ERROR");
        end
        $finish;
    end

endmodule
